/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the shortest-path RTL.
// All of them sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/bfsp_pkg.sv */
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared widths, codes and arithmetic helpers of the shortest-path engine.
// ----------------------------------------------------------------------------
package bfsp_pkg;

    localparam int W_WEIGHT    = 10;
    localparam int W_DIST      = 16;
    localparam int W_NODE      = 3;
    localparam int W_INF       = 15;
    localparam int MAX_RESULTS = 8;
    localparam int W_RES_IDX   = $clog2(MAX_RESULTS);

    localparam logic [W_INF-1:0]     INF_RESET = 15'd1000;
    localparam logic [W_RES_IDX-1:0] LAST_RES  = W_RES_IDX'(MAX_RESULTS - 1);

    localparam logic OP_EDGE_WRITE = 1'b0;
    localparam logic OP_QUERY      = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNREACH   = 2'd1,
        STATUS_NEG_CYCLE = 2'd2
    } status_t;

    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b0000000001,
        ST_IDLE     = 10'b0000000010,
        ST_INIT     = 10'b0000000100,
        ST_ROW_RD   = 10'b0000001000,
        ST_ROW_WAIT = 10'b0000010000,
        ST_EDGE     = 10'b0000100000,
        ST_DRAIN    = 10'b0001000000,
        ST_PASS_END = 10'b0010000000,
        ST_PATH_RD  = 10'b0100000000,
        ST_PATH_OUT = 10'b1000000000
    } state_t;

    // Distance plus weight, saturated to the signed 16-bit range.
    function automatic logic signed [W_DIST-1:0] sat_add(
        input logic signed [W_DIST-1:0]   a,
        input logic signed [W_WEIGHT-1:0] b
    );
        logic [W_DIST:0] s;
        s = {a[W_DIST-1], a} + {{(W_DIST + 1 - W_WEIGHT){b[W_WEIGHT-1]}}, b};
        unique case (s[W_DIST:W_DIST-1])
            2'b01:   sat_add = 16'sh7FFF;
            2'b10:   sat_add = 16'sh8000;
            default: sat_add = s[W_DIST-1:0];
        endcase
    endfunction

endpackage

/* hdl/bfsp_ram.sv */
// ----------------------------------------------------------------------------
// bfsp_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/bellman_ford_shortest_path.sv */
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path
// Bellman-Ford shortest path over an adjacency matrix held in RAM, with the
// per-node distance and predecessor held in a second RAM.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+--------------------------------------
//   request   | start, busy             | op, edge_from, edge_to, edge_weight,
//             |                         | source_node, target_node
//   result    | result_valid (strobe)   | path_node, last, status, path_distance
//   config    | cfg_valid, cfg_ready    | cfg_data (infinity distance)
//
// An edge write keeps busy low. A query seeds the distance RAM, then runs up
// to N passes (each row: a read of its own distance, then one edge per cycle
// through the weight RAM when the row node is reached), then reads out the
// path one node at a time. After reset the weight RAM is swept to zero with
// busy high. Results are single-cycle strobes that cannot be stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bellman_ford_shortest_path
    import bfsp_pkg::*;
#(
    parameter int NODE_COUNT = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       op,
    input  logic [W_NODE-1:0]          edge_from,
    input  logic [W_NODE-1:0]          edge_to,
    input  logic signed [W_WEIGHT-1:0] edge_weight,
    input  logic [W_NODE-1:0]          source_node,
    input  logic [W_NODE-1:0]          target_node,
    output logic                       result_valid,
    output logic [W_NODE-1:0]          path_node,
    output logic                       last,
    output logic [1:0]                 status,
    output logic signed [W_DIST-1:0]   path_distance,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [W_INF-1:0]           cfg_data
);

    localparam int NW     = $clog2(NODE_COUNT);
    localparam int WDEPTH = NODE_COUNT * NODE_COUNT;
    localparam int AW     = $clog2(WDEPTH);
    localparam int CW     = $clog2(NODE_COUNT + 1);

    localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WDEPTH - 1);
    localparam logic [AW-1:0] ROW_SIZE  = AW'(NODE_COUNT);

    typedef struct packed {
        logic                     has_pred;
        logic [NW-1:0]            pred;
        logic signed [W_DIST-1:0] node_dist;
    } dent_t;

    // Control registers
    state_t                state_reg,     state_next;
    logic [W_INF-1:0]      inf_reg,       inf_next;
    logic [AW-1:0]         clr_reg,       clr_next;
    logic [NW-1:0]         row_reg,       row_next;
    logic [NW-1:0]         col_reg,       col_next;
    logic                  e_valid_reg,   e_valid_next;
    logic [NW-1:0]         e_col_reg,     e_col_next;
    logic                  changed_reg,   changed_next;
    logic [CW-1:0]         pass_cnt_reg,  pass_cnt_next;
    logic [NW-1:0]         cur_reg,       cur_next;
    logic [W_RES_IDX-1:0]  k_reg,         k_next;
    logic                  res_valid_reg, res_valid_next;

    // Payload registers
    logic [NW-1:0]            src_reg,       src_next;
    logic [NW-1:0]            dst_reg,       dst_next;
    logic signed [W_DIST-1:0] row_dist_reg,  row_dist_next;
    logic signed [W_DIST-1:0] pdist_reg,     pdist_next;
    logic [W_NODE-1:0]        res_node_reg,  res_node_next;
    logic                     res_last_reg,  res_last_next;
    status_t                  res_status_reg, res_status_next;
    logic signed [W_DIST-1:0] res_dist_reg,  res_dist_next;

    // RAM ports
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [W_WEIGHT-1:0] w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [W_WEIGHT-1:0] w_rdata;
    logic                d_we;
    logic [NW-1:0]       d_waddr;
    dent_t               d_wdata;
    logic [NW-1:0]       d_raddr;
    dent_t               d_rdata;

    logic                     edge_in_range;
    logic                     query_in_range;
    logic signed [W_DIST-1:0] cand;
    logic                     relax;
    logic signed [W_DIST-1:0] dist_now;
    logic                     path_fin;

    bfsp_ram #(
        .WIDTH (W_WEIGHT),
        .DEPTH (WDEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    bfsp_ram #(
        .WIDTH ($bits(dent_t)),
        .DEPTH (NODE_COUNT)
    ) u_dist_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    assign edge_in_range  = (32'(edge_from) < 32'(NODE_COUNT))
                         && (32'(edge_to) < 32'(NODE_COUNT));
    assign query_in_range = (32'(source_node) < 32'(NODE_COUNT))
                         && (32'(target_node) < 32'(NODE_COUNT));

    // Edge stage: weight and target distance arrive in the cycle after the read.
    assign cand  = sat_add(row_dist_reg, $signed(w_rdata));
    assign relax = e_valid_reg && (w_rdata != '0) && (cand < $signed(d_rdata.node_dist));

    assign dist_now = (k_reg == '0) ? $signed(d_rdata.node_dist) : pdist_reg;
    assign path_fin = (cur_reg == src_reg) || (k_reg == LAST_RES) || !d_rdata.has_pred;

    always_comb
    begin
        state_next      = state_reg;
        inf_next        = inf_reg;
        clr_next        = clr_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        e_valid_next    = 1'b0;
        e_col_next      = e_col_reg;
        changed_next    = changed_reg;
        pass_cnt_next   = pass_cnt_reg;
        cur_next        = cur_reg;
        k_next          = k_reg;
        res_valid_next  = 1'b0;
        src_next        = src_reg;
        dst_next        = dst_reg;
        row_dist_next   = row_dist_reg;
        pdist_next      = pdist_reg;
        res_node_next   = res_node_reg;
        res_last_next   = res_last_reg;
        res_status_next = res_status_reg;
        res_dist_next   = res_dist_reg;

        w_we    = 1'b0;
        w_waddr = clr_reg;
        w_wdata = '0;
        w_raddr = AW'(row_reg) * ROW_SIZE + AW'(col_reg);
        d_we    = 1'b0;
        d_waddr = e_col_reg;
        d_wdata = '{has_pred: 1'b1, pred: row_reg, node_dist: cand};
        d_raddr = row_reg;

        if (cfg_valid)
        begin
            inf_next = cfg_data;
        end

        // Relaxation write-back; a self-loop also refreshes the row distance
        // so the rest of the row sees the new value.
        if (relax)
        begin
            d_we         = 1'b1;
            changed_next = 1'b1;
            if (e_col_reg == row_reg)
            begin
                row_dist_next = cand;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                w_we    = 1'b1;
                w_waddr = clr_reg;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_EDGE_WRITE)
                    begin
                        w_we    = edge_in_range;
                        w_waddr = AW'(edge_from) * ROW_SIZE + AW'(edge_to);
                        w_wdata = edge_weight;
                    end
                    else if (!query_in_range)
                    begin
                        res_valid_next  = 1'b1;
                        res_node_next   = target_node;
                        res_last_next   = 1'b1;
                        res_status_next = STATUS_UNREACH;
                        res_dist_next   = W_DIST'(inf_reg);
                    end
                    else
                    begin
                        src_next   = NW'(source_node);
                        dst_next   = NW'(target_node);
                        col_next   = '0;
                        state_next = ST_INIT;
                    end
                end
            end

            ST_INIT:
            begin
                d_we    = 1'b1;
                d_waddr = col_reg;
                d_wdata = '{has_pred: 1'b0, pred: '0,
                            node_dist: (col_reg == src_reg) ? '0 : W_DIST'(inf_reg)};
                if (col_reg == LAST_NODE)
                begin
                    row_next      = '0;
                    changed_next  = 1'b0;
                    pass_cnt_next = '0;
                    state_next    = ST_ROW_RD;
                end
                else
                begin
                    col_next = col_reg + NW'(1);
                end
            end

            ST_ROW_RD:
            begin
                d_raddr    = row_reg;
                state_next = ST_ROW_WAIT;
            end

            ST_ROW_WAIT:
            begin
                if ((row_reg == src_reg) || d_rdata.has_pred)
                begin
                    row_dist_next = d_rdata.node_dist;
                    col_next      = '0;
                    state_next    = ST_EDGE;
                end
                else if (row_reg == LAST_NODE)
                begin
                    state_next = ST_PASS_END;
                end
                else
                begin
                    row_next   = row_reg + NW'(1);
                    state_next = ST_ROW_RD;
                end
            end

            ST_EDGE:
            begin
                d_raddr      = col_reg;
                e_valid_next = 1'b1;
                e_col_next   = col_reg;
                if (col_reg == LAST_NODE)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    col_next = col_reg + NW'(1);
                end
            end

            ST_DRAIN:
            begin
                // The last edge of the row writes back here, before the next
                // row reads its own distance.
                if (row_reg == LAST_NODE)
                begin
                    state_next = ST_PASS_END;
                end
                else
                begin
                    row_next   = row_reg + NW'(1);
                    state_next = ST_ROW_RD;
                end
            end

            ST_PASS_END:
            begin
                pass_cnt_next = pass_cnt_reg + CW'(1);
                if (changed_reg && ((pass_cnt_reg + CW'(1)) < CW'(NODE_COUNT)))
                begin
                    changed_next = 1'b0;
                    row_next     = '0;
                    state_next   = ST_ROW_RD;
                end
                else
                begin
                    cur_next   = dst_reg;
                    k_next     = '0;
                    state_next = ST_PATH_RD;
                end
            end

            ST_PATH_RD:
            begin
                d_raddr    = cur_reg;
                state_next = ST_PATH_OUT;
            end

            ST_PATH_OUT:
            begin
                res_valid_next = 1'b1;
                res_node_next  = W_NODE'(cur_reg);
                if (k_reg == '0)
                begin
                    pdist_next = d_rdata.node_dist;
                end
                priority if (changed_reg)
                begin
                    res_last_next   = 1'b1;
                    res_status_next = STATUS_NEG_CYCLE;
                    res_dist_next   = '0;
                    state_next      = ST_IDLE;
                end
                else if ((k_reg == '0) && (cur_reg != src_reg) && !d_rdata.has_pred)
                begin
                    res_last_next   = 1'b1;
                    res_status_next = STATUS_UNREACH;
                    res_dist_next   = W_DIST'(inf_reg);
                    state_next      = ST_IDLE;
                end
                else
                begin
                    res_last_next   = path_fin;
                    res_status_next = STATUS_OK;
                    res_dist_next   = dist_now;
                    if (path_fin)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cur_next   = d_rdata.pred;
                        k_next     = k_reg + W_RES_IDX'(1);
                        state_next = ST_PATH_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            inf_reg       <= INF_RESET;
            clr_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            e_valid_reg   <= 1'b0;
            e_col_reg     <= '0;
            changed_reg   <= 1'b0;
            pass_cnt_reg  <= '0;
            cur_reg       <= '0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inf_reg       <= inf_next;
            clr_reg       <= clr_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            e_valid_reg   <= e_valid_next;
            e_col_reg     <= e_col_next;
            changed_reg   <= changed_next;
            pass_cnt_reg  <= pass_cnt_next;
            cur_reg       <= cur_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        row_dist_reg   <= row_dist_next;
        pdist_reg      <= pdist_next;
        res_node_reg   <= res_node_next;
        res_last_reg   <= res_last_next;
        res_status_reg <= res_status_next;
        res_dist_reg   <= res_dist_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_valid  = res_valid_reg;
    assign path_node     = res_node_reg;
    assign last          = res_last_reg;
    assign status        = res_status_reg;
    assign path_distance = res_dist_reg;

    `ASSERT_IMPLY(a_result_origin, res_valid_reg,
        $past(state_reg == ST_PATH_OUT) || $past(state_reg == ST_IDLE),
        "result strobe without a path or idle cycle before it")
    `ASSERT_IMPLY(a_edge_no_clash, (state_reg == ST_EDGE) && d_we,
        d_waddr != d_raddr,
        "distance write and read hit the same node in the edge stream")
    `ASSERT_IMPLY(a_weights_frozen, busy && (state_reg != ST_CLEAR), !w_we,
        "weight RAM written during a query")
    `ASSERT_ALWAYS(a_pass_bound, pass_cnt_reg <= CW'(NODE_COUNT),
        "pass count ran beyond the node count")

endmodule
